// ===== design/kcc_pkg.sv =====
// kcc_pkg: shared types and constants for the keypad calculator core.
// Holds the key and result transfer structs, the key and operator codes
// and the request/response structs of the shared arithmetic unit.
package kcc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // Decimal shift applied on digit entry
    localparam value_t DIGIT_BASE = value_t'(10);

    // Key kinds; code 7 is unused and ignored
    typedef enum logic [2:0] {
        KEY_DIGIT      = 3'd0,
        KEY_OPERATOR   = 3'd1,
        KEY_EQUALS     = 3'd2,
        KEY_MEM_ADD    = 3'd3,
        KEY_MEM_CLEAR  = 3'd4,
        KEY_MEM_RECALL = 3'd5,
        KEY_ALL_CLEAR  = 3'd6
    } key_kind_t;

    // Arithmetic operator codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_code_t;

    // One key event
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] digit_value;
        logic [1:0] operator_code;
    } key_t;

    // Calculator state after one key
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] shown_value;
        logic signed [VALUE_WIDTH-1:0] accumulated_value;
        logic signed [VALUE_WIDTH-1:0] memory_value;
        logic                          error_flag;
    } result_t;

    // Request to the shared arithmetic unit; start is a one-cycle pulse
    typedef struct packed {
        logic     start;
        op_code_t op;
        value_t   a;
        value_t   b;
    } alu_req_t;

    // Response: done pulses for one cycle, result holds until the next one
    typedef struct packed {
        logic   done;
        value_t result;
    } alu_resp_t;

endpackage

// ===== design/keypad_calculator_core_unit.sv =====
// keypad_calculator_core_unit: four-function calculator with memory.
// Key sequencer and calculator registers around kcc_alu. Depends on kcc_pkg.
//
//  channel | direction | payload         | handshake
//  key     | in        | kcc_pkg::key_t    | key_valid / key_stall
//  result  | out       | kcc_pkg::result_t | result_valid / result_stall
//
// One key at a time; key_stall is high from the transfer until the result
// is loaded into the output register. Clear, recall and ignored keys, and
// others that need no arithmetic, go straight to the output register; the
// rest wait on the shared unit, which adds and subtracts in one pass and
// multiplies and divides in bit-serial steps (a digit: multiply then add).
// A new key is taken while the last result still waits in the output
// register. Reset clears display, accumulator, memory, error and pending op.
module keypad_calculator_core_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_valid,
    output logic              key_stall,
    input  kcc_pkg::key_t     key_data,
    output logic              result_valid,
    input  logic              result_stall,
    output kcc_pkg::result_t  result_data
);
    import kcc_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE,
        T_DIG_MUL,
        T_DIG_ADD,
        T_ARITH,
        T_MEM_ADD,
        T_FINISH
    } state_t;

    state_t     state_reg, state_next;
    key_t       key_reg, key_next;
    value_t     display_reg, display_next;
    value_t     acc_reg, acc_next;
    value_t     mem_reg, mem_next;
    logic       pend_valid_reg, pend_valid_next;
    op_code_t   pend_op_reg, pend_op_next;
    logic       err_reg, err_next;
    alu_req_t   alu_req_reg, alu_req_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    alu_resp_t  alu_resp;
    logic       key_accept;
    logic       div_by_zero;

    kcc_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (alu_req_reg),
        .resp (alu_resp)
    );

    assign key_stall   = (state_reg != T_IDLE);
    assign key_accept  = key_valid && !key_stall;
    assign div_by_zero = (pend_op_reg == OP_DIV) && (display_reg == '0);

    // Key sequencer
    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        display_next    = display_reg;
        acc_next        = acc_reg;
        mem_next        = mem_reg;
        pend_valid_next = pend_valid_reg;
        pend_op_next    = pend_op_reg;
        err_next        = err_reg;
        alu_req_next       = alu_req_reg;
        alu_req_next.start = 1'b0;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        // output register empties on a transfer
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (key_accept)
                begin
                    key_next   = key_data;
                    state_next = T_FINISH;
                    case (key_data.kind)
                        KEY_DIGIT:
                        begin
                            if (!err_reg)
                            begin
                                alu_req_next = '{start: 1'b1, op: OP_MUL,
                                                 a: display_reg, b: DIGIT_BASE};
                                state_next   = T_DIG_MUL;
                            end
                        end
                        KEY_OPERATOR:
                        begin
                            display_next = '0;
                            if (!pend_valid_reg)
                            begin
                                pend_valid_next = 1'b1;
                                pend_op_next    = op_code_t'(key_data.operator_code);
                                acc_next        = display_reg;
                            end
                            else if (!err_reg)
                            begin
                                if (div_by_zero)
                                begin
                                    err_next     = 1'b1;
                                    acc_next     = '0;
                                    pend_op_next = op_code_t'(key_data.operator_code);
                                end
                                else
                                begin
                                    alu_req_next = '{start: 1'b1, op: pend_op_reg,
                                                     a: acc_reg, b: display_reg};
                                    state_next   = T_ARITH;
                                end
                            end
                        end
                        KEY_EQUALS:
                        begin
                            pend_valid_next = 1'b0;
                            if (!err_reg && pend_valid_reg)
                            begin
                                if (div_by_zero)
                                begin
                                    err_next = 1'b1;
                                    acc_next = '0;
                                end
                                else
                                begin
                                    alu_req_next = '{start: 1'b1, op: pend_op_reg,
                                                     a: acc_reg, b: display_reg};
                                    state_next   = T_ARITH;
                                end
                            end
                        end
                        KEY_MEM_ADD:
                        begin
                            if (!err_reg)
                            begin
                                alu_req_next = '{start: 1'b1, op: OP_ADD,
                                                 a: mem_reg, b: display_reg};
                                state_next   = T_MEM_ADD;
                            end
                        end
                        KEY_MEM_CLEAR:
                        begin
                            if (!err_reg)
                            begin
                                mem_next = '0;
                            end
                        end
                        KEY_MEM_RECALL:
                        begin
                            if (!err_reg)
                            begin
                                display_next = mem_reg;
                            end
                        end
                        KEY_ALL_CLEAR:
                        begin
                            display_next    = '0;
                            acc_next        = '0;
                            mem_next        = '0;
                            pend_valid_next = 1'b0;
                            pend_op_next    = OP_ADD;
                            err_next        = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            T_DIG_MUL:
            begin
                if (alu_resp.done)
                begin
                    alu_req_next = '{start: 1'b1, op: OP_ADD, a: alu_resp.result,
                                     b: value_t'(key_reg.digit_value)};
                    state_next   = T_DIG_ADD;
                end
            end
            T_DIG_ADD:
            begin
                if (alu_resp.done)
                begin
                    display_next = alu_resp.result;
                    state_next   = T_FINISH;
                end
            end
            T_ARITH:
            begin
                if (alu_resp.done)
                begin
                    acc_next = alu_resp.result;
                    if (key_reg.kind == KEY_OPERATOR)
                    begin
                        pend_op_next = op_code_t'(key_reg.operator_code);
                    end
                    else
                    begin
                        display_next = alu_resp.result;
                    end
                    state_next = T_FINISH;
                end
            end
            T_MEM_ADD:
            begin
                if (alu_resp.done)
                begin
                    mem_next   = alu_resp.result;
                    state_next = T_FINISH;
                end
            end
            T_FINISH:
            begin
                // load the output register once it is free or being emptied
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{shown_value:       display_reg,
                                       accumulated_value: acc_reg,
                                       memory_value:      mem_reg,
                                       error_flag:        err_reg};
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            key_reg        <= '0;
            display_reg    <= '0;
            acc_reg        <= '0;
            mem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_op_reg    <= OP_ADD;
            err_reg        <= 1'b0;
            alu_req_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            key_reg        <= key_next;
            display_reg    <= display_next;
            acc_reg        <= acc_next;
            mem_reg        <= mem_next;
            pend_valid_reg <= pend_valid_next;
            pend_op_reg    <= pend_op_next;
            err_reg        <= err_next;
            alu_req_reg    <= alu_req_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

// ===== design/kcc_alu.sv =====
// kcc_alu: shared iterative arithmetic unit with one adder/subtractor.
// Add and subtract in one pass, shift-add multiply and restoring divide
// one bit per cycle. Depends on kcc_pkg.
module kcc_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  kcc_pkg::alu_req_t   req,
    output kcc_pkg::alu_resp_t  resp
);
    import kcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_MUL,
        S_ABS_A,
        S_ABS_B,
        S_DIV,
        S_NEG_Q
    } state_t;

    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(VALUE_WIDTH - 1);

    state_t                 state_reg, state_next;
    op_code_t               op_reg, op_next;
    value_t                 x_reg, x_next;     // addend / multiplicand / divisor
    value_t                 y_reg, y_next;     // augend / multiplier / dividend-quotient
    value_t                 r_reg, r_next;     // product / remainder
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   neg_q_reg, neg_q_next;
    logic                   done_reg, done_next;
    value_t                 res_reg, res_next;

    logic [VALUE_WIDTH:0]   add_a;
    logic [VALUE_WIDTH:0]   add_b;
    logic                   add_cin;
    logic [VALUE_WIDTH:0]   sum;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic                   q_bit;

    // The one adder every operation goes through
    assign sum       = add_a + add_b + {{VALUE_WIDTH{1'b0}}, add_cin};
    assign rem_shift = {r_reg, y_reg[VALUE_WIDTH-1]};
    assign q_bit     = ~sum[VALUE_WIDTH];

    // Adder operand selection per step
    always_comb
    begin
        add_a   = {1'b0, y_reg};
        add_b   = {1'b0, x_reg};
        add_cin = 1'b0;
        unique case (state_reg)
            S_ADD:
            begin
                if (op_reg == OP_SUB)
                begin
                    add_b   = {1'b0, ~x_reg};
                    add_cin = 1'b1;
                end
            end
            S_MUL:
            begin
                add_a = {1'b0, r_reg};
            end
            S_ABS_A, S_NEG_Q:
            begin
                add_a   = '0;
                add_b   = {1'b0, ~y_reg};
                add_cin = 1'b1;
            end
            S_ABS_B:
            begin
                add_a   = '0;
                add_b   = {1'b0, ~x_reg};
                add_cin = 1'b1;
            end
            S_DIV:
            begin
                add_a   = rem_shift;
                add_b   = ~{1'b0, x_reg};
                add_cin = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencing of the unit
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        neg_q_next = neg_q_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    y_next     = req.a;
                    x_next     = req.b;
                    r_next     = '0;
                    cnt_next   = '0;
                    neg_q_next = req.a[VALUE_WIDTH-1] ^ req.b[VALUE_WIDTH-1];
                    unique case (req.op)
                        OP_ADD, OP_SUB: state_next = S_ADD;
                        OP_MUL:         state_next = S_MUL;
                        OP_DIV:         state_next = S_ABS_A;
                        default:        state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                res_next   = sum[VALUE_WIDTH-1:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_MUL:
            begin
                // low product bits only: wraparound is the wanted result
                if (y_reg[0])
                begin
                    r_next = sum[VALUE_WIDTH-1:0];
                end
                x_next   = x_reg << 1;
                y_next   = y_reg >> 1;
                cnt_next = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    res_next   = y_reg[0] ? sum[VALUE_WIDTH-1:0] : r_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ABS_A:
            begin
                if (y_reg[VALUE_WIDTH-1])
                begin
                    y_next = sum[VALUE_WIDTH-1:0];
                end
                state_next = S_ABS_B;
            end
            S_ABS_B:
            begin
                if (x_reg[VALUE_WIDTH-1])
                begin
                    x_next = sum[VALUE_WIDTH-1:0];
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restoring step on magnitudes, quotient shifts into y
                r_next   = q_bit ? sum[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
                y_next   = {y_reg[VALUE_WIDTH-2:0], q_bit};
                cnt_next = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_NEG_Q;
                end
            end
            S_NEG_Q:
            begin
                res_next   = neg_q_reg ? sum[VALUE_WIDTH-1:0] : y_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ADD;
            x_reg     <= '0;
            y_reg     <= '0;
            r_reg     <= '0;
            cnt_reg   <= '0;
            neg_q_reg <= 1'b0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            r_reg     <= r_next;
            cnt_reg   <= cnt_next;
            neg_q_reg <= neg_q_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    assign resp.done   = done_reg;
    assign resp.result = res_reg;

endmodule

// ===== design/kcc_checker.sv =====
// kcc_checker: port-level assertions for keypad_calculator_core_unit,
// attached by the bind statement at the end. Depends on kcc_pkg.
module kcc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              key_valid,
    input logic              key_stall,
    input logic              result_valid,
    input logic              result_stall,
    input kcc_pkg::result_t  result_data
);
    import kcc_pkg::*;

    logic [1:0] open_cnt_reg, open_cnt_next;
    logic       key_xfer;
    logic       result_xfer;

    assign key_xfer    = key_valid && !key_stall;
    assign result_xfer = result_valid && !result_stall;

    // keys taken but whose result has not been transferred yet
    always_comb
    begin
        open_cnt_next = open_cnt_reg;
        if (key_xfer && !result_xfer)
        begin
            open_cnt_next = open_cnt_reg + 2'd1;
        end
        else if (!key_xfer && result_xfer)
        begin
            open_cnt_next = open_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_cnt_reg <= '0;
        end
        else
        begin
            open_cnt_reg <= open_cnt_next;
        end
    end

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // one key at a time: busy right after a key transfer
    a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
        key_xfer |=> key_stall)
        else $error("key taken while previous key in progress");

    // never a result without a key behind it
    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> open_cnt_reg != 2'd0)
        else $error("result shown without an open key");

    // at most one key in work plus one result waiting
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_cnt_reg != 2'd3)
        else $error("too many keys open");

endmodule

bind keypad_calculator_core_unit kcc_checker u_kcc_checker (.*);

// ===== test/keypad_calculator_core_unit_tb.sv =====
// keypad_calculator_core_unit_tb: self-checking testbench for the keypad calculator core.
// Drives key transfers, predicts each result transfer and compares it field by field.
// Depends on kcc_pkg and keypad_calculator_core_unit.
`timescale 1ns / 1ps

module keypad_calculator_core_unit_tb;

    import kcc_pkg::*;

    localparam logic [2:0] KEY_UNUSED   = 3'd7;
    localparam logic [2:0] PENDING_NONE = 3'd4;
    localparam value_t     VALUE_MIN    = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam value_t     MINUS_ONE    = '1;
    localparam int         TARGET_KEYS  = 700;

    logic    clk;
    logic    rst_n;
    logic    key_valid;
    logic    key_stall;
    key_t    key_data;
    logic    result_valid;
    logic    result_stall;
    result_t result_data;

    keypad_calculator_core_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_data     (key_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Directed stimulus row; want is used only when checked is set
    typedef struct {
        key_t    key;
        bit      checked;
        result_t want;
    } key_row_t;

    key_row_t    directed_keys[$];
    result_t     expected_results[$];
    int          mismatch_count;
    int unsigned random_key_count;
    bit          gaps_enabled;

    // Calculator state as predicted
    value_t      calc_display;
    value_t      calc_accum;
    value_t      calc_memory;
    logic [2:0]  calc_pending;
    logic        calc_error;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic result_t make_state(value_t shown, value_t acc, value_t mem, logic err);
        result_t r;
        r.shown_value       = shown;
        r.accumulated_value = acc;
        r.memory_value      = mem;
        r.error_flag        = err;
        return r;
    endfunction

    function automatic key_t make_key(logic [2:0] kind, logic [3:0] dig, logic [1:0] op);
        key_t k;
        k.kind          = kind;
        k.digit_value   = dig;
        k.operator_code = op;
        return k;
    endfunction

    // Signed divide truncating toward zero; the most negative value over -1 wraps to itself
    function automatic value_t signed_quotient(value_t num, value_t den);
        value_t mag_num;
        value_t mag_den;
        value_t q;
        mag_num = num[VALUE_WIDTH-1] ? -num : num;
        mag_den = den[VALUE_WIDTH-1] ? -den : den;
        q = mag_num / mag_den;
        return (num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1]) ? -q : q;
    endfunction

    // Pending operator applied to accumulator and display; 0 on divide by zero
    function automatic bit fold_pending(output value_t res);
        res = '0;
        case (op_code_t'(calc_pending[1:0]))
            OP_ADD: res = calc_accum + calc_display;
            OP_SUB: res = calc_accum - calc_display;
            OP_MUL: res = calc_accum * calc_display;
            default:
            begin
                if (calc_display == '0)
                    return 1'b0;
                res = signed_quotient(calc_accum, calc_display);
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void clear_calculator();
        calc_display = '0;
        calc_accum   = '0;
        calc_memory  = '0;
        calc_pending = PENDING_NONE;
        calc_error   = 1'b0;
    endfunction

    // Advance the predicted calculator by one key and return the state after it
    function automatic result_t calculate_key(key_t k);
        value_t res;
        case (k.kind)
            KEY_DIGIT:
            begin
                if (!calc_error)
                    calc_display = calc_display * DIGIT_BASE + value_t'(k.digit_value);
            end
            KEY_OPERATOR:
            begin
                if (calc_pending == PENDING_NONE)
                begin
                    calc_pending = {1'b0, k.operator_code};
                    calc_accum   = calc_display;
                end
                else if (!calc_error)
                begin
                    if (fold_pending(res))
                        calc_accum = res;
                    else
                    begin
                        calc_error = 1'b1;
                        calc_accum = '0;
                    end
                    calc_pending = {1'b0, k.operator_code};
                end
                calc_display = '0;
            end
            KEY_EQUALS:
            begin
                if (!calc_error && calc_pending != PENDING_NONE)
                begin
                    if (fold_pending(res))
                    begin
                        calc_accum   = res;
                        calc_display = res;
                    end
                    else
                    begin
                        calc_error = 1'b1;
                        calc_accum = '0;
                    end
                end
                calc_pending = PENDING_NONE;
            end
            KEY_MEM_ADD:
            begin
                if (!calc_error)
                    calc_memory = calc_memory + calc_display;
            end
            KEY_MEM_CLEAR:
            begin
                if (!calc_error)
                    calc_memory = '0;
            end
            KEY_MEM_RECALL:
            begin
                if (!calc_error)
                    calc_display = calc_memory;
            end
            KEY_ALL_CLEAR:
                clear_calculator();
            default:
                ;
        endcase
        return make_state(calc_display, calc_accum, calc_memory, calc_error);
    endfunction

    // One key transfer, after a random gap if enabled; queues the expected result on acceptance
    task automatic send_key(key_t k, bit checked, result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = gaps_enabled ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            key_valid <= 1'b0;
            key_data  <= key_t'(9'($urandom_range(0, 511)));
        end
        @(negedge clk);
        key_valid <= 1'b1;
        key_data  <= k;
        do
            @(posedge clk);
        while (key_stall);
        predicted = calculate_key(k);
        expected_results.push_back(checked ? want : predicted);
        if (k.kind != KEY_UNUSED)
            random_key_count++;
    endtask

    task automatic send_plain(logic [2:0] kind, logic [3:0] dig, logic [1:0] op);
        send_key(make_key(kind, dig, op), 1'b0, '0);
    endtask

    task automatic table_row(logic [2:0] kind, logic [3:0] dig, logic [1:0] op,
                             bit checked, result_t want);
        key_row_t row;
        row.key     = make_key(kind, dig, op);
        row.checked = checked;
        row.want    = want;
        directed_keys.push_back(row);
    endtask

    // Operand: digits (mostly few, sometimes enough to wrap, sometimes none) or a recall
    task automatic enter_number();
        int unsigned r;
        int unsigned len;
        logic [3:0]  d;
        r = $urandom_range(0, 99);
        if (r >= 92)
        begin
            send_plain(KEY_MEM_RECALL, 4'($urandom), 2'($urandom));
            return;
        end
        if (r < 8)
            len = 0;
        else if (r < 16)
            len = $urandom_range(8, 11);
        else
            len = $urandom_range(1, 3);
        repeat (len)
        begin
            d = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            send_plain(KEY_DIGIT, d, 2'($urandom));
        end
    endtask

    // One random key sequence: mostly well-formed expressions, some memory keys and noise
    task automatic send_random_sequence();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calc_error && $urandom_range(0, 1) == 0)
            send_plain(KEY_ALL_CLEAR, 4'($urandom), 2'($urandom));
        else if (r < 65)
        begin
            enter_number();
            repeat ($urandom_range(1, 3))
            begin
                send_plain(KEY_OPERATOR, 4'($urandom), 2'($urandom_range(0, 3)));
                enter_number();
            end
            if ($urandom_range(0, 3) != 0)
                send_plain(KEY_EQUALS, 4'($urandom), 2'($urandom));
            if ($urandom_range(0, 4) == 0)
                send_plain(KEY_MEM_ADD, 4'($urandom), 2'($urandom));
        end
        else if (r < 78)
            send_plain(3'($urandom_range(KEY_MEM_ADD, KEY_MEM_RECALL)), 4'($urandom),
                       2'($urandom));
        else if (r < 84)
            send_plain(KEY_ALL_CLEAR, 4'($urandom), 2'($urandom));
        else if (r < 90)
            send_plain(KEY_EQUALS, 4'($urandom), 2'($urandom));
        else
        begin
            repeat ($urandom_range(1, 4))
                send_key(key_t'(9'($urandom_range(0, 511))), 1'b0, '0);
        end
    endtask

    // Sender pauses: valid drops, then wait for every expected result
    task automatic drain_results();
        @(negedge clk);
        key_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string name, logic signed [VALUE_WIDTH-1:0] want,
                               logic signed [VALUE_WIDTH-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result receiver: random stalls, with stretches of none
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(30, 80))
                begin
                    @(negedge clk);
                    result_stall <= 1'b0;
                end
            end
            repeat (pick_gap())
            begin
                @(negedge clk);
                result_stall <= 1'b1;
            end
            repeat ($urandom_range(1, 6))
            begin
                @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, got %0d %0d %0d %0b",
                         $time, result_data.shown_value, result_data.accumulated_value,
                         result_data.memory_value, result_data.error_flag);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("shown_value", want.shown_value, result_data.shown_value);
                check_field("accumulated_value", want.accumulated_value,
                            result_data.accumulated_value);
                check_field("memory_value", want.memory_value, result_data.memory_value);
                check_field("error_flag", VALUE_WIDTH'(want.error_flag),
                            VALUE_WIDTH'(result_data.error_flag));
            end
        end
    end

    // Stimulus
    initial
    begin
        string       big_number;
        int unsigned next_drain;
        rst_n            = 1'b0;
        key_valid        = 1'b0;
        key_data         = '0;
        mismatch_count   = 0;
        random_key_count = 0;
        gaps_enabled     = 1'b1;
        next_drain       = 150;
        big_number       = "2147483648";
        clear_calculator();

        // After reset, and an unused kind with all other bits set
        table_row(KEY_MEM_RECALL, 4'd0, OP_ADD, 1'b1, make_state('0, '0, '0, 1'b0));
        table_row(KEY_UNUSED, 4'd15, OP_DIV, 1'b1, make_state('0, '0, '0, 1'b0));
        // Minus one into memory
        table_row(KEY_OPERATOR, 4'd0, OP_SUB, 1'b0, '0);
        table_row(KEY_DIGIT, 4'd1, OP_ADD, 1'b0, '0);
        table_row(KEY_EQUALS, 4'd0, OP_ADD, 1'b0, '0);
        table_row(KEY_MEM_ADD, 4'd0, OP_ADD, 1'b0, '0);
        // Minus one times a digit entry that wraps to the most negative value
        table_row(KEY_OPERATOR, 4'd0, OP_MUL, 1'b0, '0);
        for (int i = 0; i < big_number.len(); i++)
            table_row(KEY_DIGIT, 4'(big_number[i] - "0"), OP_ADD, 1'b0, '0);
        table_row(KEY_EQUALS, 4'd0, OP_ADD, 1'b0, '0);
        // Most negative value over minus one wraps to itself
        table_row(KEY_OPERATOR, 4'd0, OP_DIV, 1'b0, '0);
        table_row(KEY_MEM_RECALL, 4'd0, OP_ADD, 1'b0, '0);
        table_row(KEY_EQUALS, 4'd0, OP_ADD, 1'b1,
                  make_state(VALUE_MIN, VALUE_MIN, MINUS_ONE, 1'b0));
        // Divide by zero, then keys while the error holds, and an all clear
        table_row(KEY_OPERATOR, 4'd0, OP_DIV, 1'b0, '0);
        table_row(KEY_EQUALS, 4'd0, OP_ADD, 1'b1, make_state('0, '0, MINUS_ONE, 1'b1));
        table_row(KEY_DIGIT, 4'd15, OP_ADD, 1'b1, make_state('0, '0, MINUS_ONE, 1'b1));
        table_row(KEY_OPERATOR, 4'd0, OP_ADD, 1'b0, '0);
        table_row(KEY_OPERATOR, 4'd0, OP_MUL, 1'b0, '0);
        table_row(KEY_EQUALS, 4'd0, OP_ADD, 1'b0, '0);
        table_row(KEY_MEM_CLEAR, 4'd0, OP_ADD, 1'b1, make_state('0, '0, MINUS_ONE, 1'b1));
        table_row(KEY_ALL_CLEAR, 4'd0, OP_ADD, 1'b1, make_state('0, '0, '0, 1'b0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_keys[i])
            send_key(directed_keys[i].key, directed_keys[i].checked, directed_keys[i].want);

        // Random part
        random_key_count = 0;
        while (random_key_count < TARGET_KEYS)
        begin
            send_random_sequence();
            if (random_key_count >= next_drain)
            begin
                next_drain += 150;
                gaps_enabled = ($urandom_range(0, 2) != 0);
                drain_results();
            end
        end

        drain_results();
        repeat (100) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
